// ===== rtl/erg_pkg.sv =====
`default_nettype none

package erg_pkg;

    // load and step strobes for a serial arithmetic unit
    typedef struct packed {
        logic load;
        logic step;
    } erg_ctl_t;

    // command codes carried in s_tuser
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_PLAY  = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_RESET = 2'd3;

    // easing curves
    localparam logic [1:0] EASE_LINEAR = 2'd0;
    localparam logic [1:0] EASE_IN     = 2'd1;
    localparam logic [1:0] EASE_OUT    = 2'd2;
    localparam logic [1:0] EASE_INOUT  = 2'd3;

    // register file
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_START    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_END      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DURATION = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_EASE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOOP     = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/erg_serial_div.sv =====
`default_nettype none

module erg_serial_div #(
    parameter int TB = 16,
    parameter int NW = 17
) (
    input  logic               aclk,
    input  erg_pkg::erg_ctl_t  ctl,
    input  logic [TB-1:0]      rem_init,
    input  logic [NW-1:0]      num_init,
    input  logic [TB-1:0]      divisor,
    output logic [TB-1:0]      rem,
    output logic [NW-1:0]      num
);
    import erg_pkg::*;

    logic [TB-1:0] rem_reg, rem_next;
    logic [NW-1:0] num_reg, num_next;
    logic [TB:0]   shifted;
    logic [TB+1:0] trial;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    always_comb begin
        shifted  = {rem_reg, num_reg[NW-1]};
        trial    = {1'b0, shifted} - {2'b00, divisor};
        rem_next = rem_reg;
        num_next = num_reg;
        if (ctl.load) begin
            rem_next = rem_init;
            num_next = num_init;
        end else if (ctl.step) begin
            if (trial[TB+1]) begin
                rem_next = shifted[TB-1:0];
                num_next = {num_reg[NW-2:0], 1'b0};
            end else begin
                rem_next = trial[TB-1:0];
                num_next = {num_reg[NW-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        num_reg <= num_next;
    end

    assign rem = rem_reg;
    assign num = num_reg;

endmodule

`default_nettype wire

// ===== rtl/erg_serial_mul.sv =====
`default_nettype none

module erg_serial_mul #(
    parameter int AW = 18,
    parameter int BW = 17
) (
    input  logic               aclk,
    input  erg_pkg::erg_ctl_t  ctl,
    input  logic [AW-1:0]      a_init,
    input  logic [BW-1:0]      b_init,
    output logic [AW+BW:0]     prod
);
    import erg_pkg::*;

    logic [AW-1:0]  a_reg, a_next;
    logic [AW+BW:0] p_reg, p_next;
    logic [AW:0]    addend;
    logic [AW:0]    acc_sum;

    // signed multiplicand times unsigned multiplier, one multiplier bit a cycle while step is set
    always_comb begin
        addend  = p_reg[0] ? {a_reg[AW-1], a_reg} : '0;
        acc_sum = p_reg[AW+BW:BW] + addend;
        a_next  = a_reg;
        p_next  = p_reg;
        if (ctl.load) begin
            a_next = a_init;
            p_next = {{(AW+1){1'b0}}, b_init};
        end else if (ctl.step) begin
            p_next = {acc_sum[AW], acc_sum, p_reg[BW-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        p_reg <= p_next;
    end

    assign prod = p_reg;

endmodule

`default_nettype wire

// ===== rtl/eased_ramp_generator.sv =====
// channel | direction | tdata (lsb up)                                  | tuser
// s_      | in        | tick_count                                      | kind
// m_      | out       | ramp_value, progress_fraction, is_playing,      | -
//         |           | is_finished                                     |
// apb     | in/out    | start, end, duration, ease mode, loop enable at byte addresses 0..16
//
// each item runs in order through a bit-serial division for the loop wrap (on a wrap only),
// a bit-serial division for progress (when progress is below one), a bit-serial square (for
// a quadratic curve) and a bit-serial multiply that scales the span
// reset is synchronous, active low; it clears the configuration and control registers
// an item is taken only while the sequencer is idle; a finished result waits in the output
// register; the next result then waits in the output state, and no item is taken meanwhile
`default_nettype none

module eased_ramp_generator #(
    parameter int VALUE_BITS    = 16,
    parameter int TIME_BITS     = 16,
    parameter int FRACTION_BITS = 16,
    localparam int IN_TDATA_W   = ((TIME_BITS + 7) / 8) * 8,
    localparam int OUT_BITS     = VALUE_BITS + FRACTION_BITS + 3,
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input item channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_TDATA_W-1:0]             s_tdata,   // tick_count
    input  logic [1:0]                        s_tuser,   // kind
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_TDATA_W-1:0]            m_tdata,   // ramp_value, progress_fraction,
                                                         // is_playing, is_finished
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [erg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [erg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [erg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import erg_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int TB = TIME_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int NW = (TB + 1 > FB) ? TB + 1 : FB;
    localparam int AW = (VB + 1 > FB + 2) ? VB + 1 : FB + 2;
    localparam int STEPS_MAX = (NW > FB + 1) ? NW : FB + 1;
    localparam int CW = $clog2(STEPS_MAX + 1);
    localparam logic [FB:0] ONE_Q = {1'b1, {FB{1'b0}}};

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_WRAP     = 4'd1;
    localparam logic [3:0] ST_WRAPDONE = 4'd2;
    localparam logic [3:0] ST_PROG     = 4'd3;
    localparam logic [3:0] ST_DIV      = 4'd4;
    localparam logic [3:0] ST_DIVDONE  = 4'd5;
    localparam logic [3:0] ST_EASE     = 4'd6;
    localparam logic [3:0] ST_SQ       = 4'd7;
    localparam logic [3:0] ST_SQDONE   = 4'd8;
    localparam logic [3:0] ST_VAL      = 4'd9;
    localparam logic [3:0] ST_OUT      = 4'd10;

    // configuration registers
    logic [VB-1:0] start_reg;
    logic [VB-1:0] end_reg;
    logic [TB-1:0] duration_reg;
    logic [1:0]    ease_reg;
    logic          loop_reg;

    // ramp state and sequencer
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [TB-1:0] elapsed_reg, elapsed_next;
    logic          playing_reg, playing_next;
    logic          finished_reg, finished_next;
    logic [FB:0]   p_reg, p_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [OUT_BITS-1:0] out_reg, out_next;

    // arithmetic units
    erg_ctl_t       div_ctl, mul_ctl;
    logic [TB-1:0]  div_rem_init, div_rem;
    logic [NW-1:0]  div_num_init, div_num;
    logic [AW-1:0]  mul_a;
    logic [FB:0]    mul_b;
    logic [AW+FB+1:0] mul_prod;

    // datapath helpers
    logic [1:0]          in_kind;
    logic [TB-1:0]       in_tick;
    logic [TB:0]         tick_sum;
    logic                sum_reaches_end;
    logic                cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                p_lt_half;
    logic                use_q;
    logic [FB:0]         q_val;
    logic [FB:0]         x_val;
    logic [FB:0]         sq_bits;
    logic                keep_direct;
    logic [FB:0]         ease_val;
    logic signed [VB:0]  span;
    logic signed [VB+1:0] t_hi;
    logic                round_up;
    logic [VB+1:0]       result_full;

    assign in_kind = s_tuser;
    assign in_tick = s_tdata[TB-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg);
    assign pready   = 1'b1;

    // register port
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg    <= '0;
            end_reg      <= '0;
            duration_reg <= '0;
            ease_reg     <= EASE_LINEAR;
            loop_reg     <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_START:    start_reg    <= pwdata[VB-1:0];
                REG_END:      end_reg      <= pwdata[VB-1:0];
                REG_DURATION: duration_reg <= pwdata[TB-1:0];
                REG_EASE:     ease_reg     <= pwdata[1:0];
                REG_LOOP:     loop_reg     <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_START:    prdata = APB_DATA_W'(start_reg);
            REG_END:      prdata = APB_DATA_W'(end_reg);
            REG_DURATION: prdata = APB_DATA_W'(duration_reg);
            REG_EASE:     prdata = APB_DATA_W'(ease_reg);
            REG_LOOP:     prdata = APB_DATA_W'(loop_reg);
            default:      prdata = '0;
        endcase
    end

    // tick accumulation
    assign tick_sum        = {1'b0, elapsed_reg} + {1'b0, in_tick};
    assign sum_reaches_end = (tick_sum >= {1'b0, duration_reg});

    // easing operand and curve from the square
    assign p_lt_half   = !p_reg[FB] && !p_reg[FB-1];
    assign q_val       = ONE_Q - p_reg;
    assign use_q       = (ease_reg == EASE_OUT) || ((ease_reg == EASE_INOUT) && !p_lt_half);
    assign x_val       = use_q ? q_val : p_reg;
    assign sq_bits     = (ease_reg == EASE_INOUT) ? mul_prod[2*FB-1:FB-1]
                                                  : mul_prod[2*FB:FB];
    assign keep_direct = (ease_reg == EASE_IN) || ((ease_reg == EASE_INOUT) && p_lt_half);
    assign ease_val    = keep_direct ? sq_bits : ONE_Q - sq_bits;

    // final value: start plus scaled span, truncated toward zero
    assign span        = $signed({end_reg[VB-1], end_reg}) - $signed({start_reg[VB-1], start_reg});
    assign t_hi        = $signed({{2{start_reg[VB-1]}}, start_reg})
                       + $signed(mul_prod[FB+VB+1:FB]);
    assign round_up    = t_hi[VB+1] && (|mul_prod[FB-1:0]);
    assign result_full = t_hi + (VB+2)'(round_up);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        elapsed_next  = elapsed_reg;
        playing_next  = playing_reg;
        finished_next = finished_reg;
        p_next        = p_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;
        div_ctl       = '0;
        mul_ctl       = '0;
        div_rem_init  = '0;
        div_num_init  = '0;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PROG;
                    case (in_kind)
                        KIND_PLAY: begin
                            playing_next  = 1'b1;
                            elapsed_next  = '0;
                            finished_next = (duration_reg == '0) ? !loop_reg : 1'b0;
                        end
                        KIND_STOP: begin
                            playing_next = 1'b0;
                        end
                        KIND_RESET: begin
                            playing_next  = 1'b0;
                            finished_next = 1'b0;
                            elapsed_next  = '0;
                        end
                        KIND_TICK: begin
                            if (playing_reg) begin
                                if (duration_reg == '0) begin
                                    finished_next = !loop_reg;
                                end else if (!sum_reaches_end) begin
                                    elapsed_next = tick_sum[TB-1:0];
                                end else if (loop_reg) begin
                                    div_ctl.load = 1'b1;
                                    div_num_init = NW'(tick_sum);
                                    cnt_next     = CW'(NW);
                                    state_next   = ST_WRAP;
                                end else begin
                                    elapsed_next  = duration_reg;
                                    playing_next  = 1'b0;
                                    finished_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WRAP: begin
                div_ctl.step = 1'b1;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_WRAPDONE;
                end
            end
            ST_WRAPDONE: begin
                elapsed_next = div_rem;
                state_next   = ST_PROG;
            end
            ST_PROG: begin
                if ((duration_reg == '0) || (elapsed_reg >= duration_reg)) begin
                    p_next     = ONE_Q;
                    state_next = ST_EASE;
                end else begin
                    div_ctl.load = 1'b1;
                    div_rem_init = elapsed_reg;
                    cnt_next     = CW'(FB);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                div_ctl.step = 1'b1;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_DIVDONE;
                end
            end
            ST_DIVDONE: begin
                p_next     = {1'b0, div_num[FB-1:0]};
                state_next = ST_EASE;
            end
            ST_EASE: begin
                mul_ctl.load = 1'b1;
                cnt_next     = CW'(FB + 1);
                if (ease_reg == EASE_LINEAR) begin
                    mul_a      = AW'(span);
                    mul_b      = p_reg;
                    state_next = ST_VAL;
                end else begin
                    mul_a      = AW'(x_val);
                    mul_b      = x_val;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                mul_ctl.step = 1'b1;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_SQDONE;
                end
            end
            ST_SQDONE: begin
                mul_ctl.load = 1'b1;
                mul_a        = AW'(span);
                mul_b        = ease_val;
                cnt_next     = CW'(FB + 1);
                state_next   = ST_VAL;
            end
            ST_VAL: begin
                mul_ctl.step = 1'b1;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = {finished_reg, playing_reg, p_reg, result_full[VB-1:0]};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            elapsed_reg  <= '0;
            playing_reg  <= 1'b0;
            finished_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            elapsed_reg  <= elapsed_next;
            playing_reg  <= playing_next;
            finished_reg <= finished_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        p_reg   <= p_next;
        out_reg <= out_next;
    end

    // shared remainder unit for loop wrap and progress
    erg_serial_div #(
        .TB (TB),
        .NW (NW)
    ) u_div (
        .aclk     (aclk),
        .ctl      (div_ctl),
        .rem_init (div_rem_init),
        .num_init (div_num_init),
        .divisor  (duration_reg),
        .rem      (div_rem),
        .num      (div_num)
    );

    // shared multiplier for the square and the span scaling
    erg_serial_mul #(
        .AW (AW),
        .BW (FB + 1)
    ) u_mul (
        .aclk   (aclk),
        .ctl    (mul_ctl),
        .a_init (mul_a),
        .b_init (mul_b),
        .prod   (mul_prod)
    );

    // a result appears only from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

    // a waiting result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_tvalid && !m_tready) |=> (state_reg == ST_OUT))
        else $error("pending result overwritten");

    // the running remainder stays below the duration
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_WRAP) |-> (div_rem < duration_reg))
        else $error("remainder out of range");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import erg_pkg::*;

    localparam longint ONE_Q          = 65536;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     SETTLE_CYCLES  = 80;
    localparam int     RANDOM_PHASES  = 12;
    localparam int     PHASE_ITEMS    = 72;

    // result item as it sits in m_tdata, lsb first: value, progress, playing, finished, padding
    typedef struct packed {
        logic [4:0]  pad;
        logic        finished;
        logic        playing;
        logic [16:0] progress;
        logic [15:0] value;
    } ramp_result_t;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_TOGGLE} stall_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;    // tick_count
    logic [1:0]            s_tuser;    // kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;    // ramp_value, progress_fraction, is_playing, is_finished
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow of the registers and the ramp state
    logic signed [15:0] cfg_from      = '0;
    logic signed [15:0] cfg_to        = '0;
    logic [15:0]        cfg_duration  = '0;
    logic [1:0]         cfg_ease      = EASE_LINEAR;
    logic               cfg_loop      = 1'b0;
    logic [15:0]        ramp_elapsed  = '0;
    logic               ramp_playing  = 1'b0;
    logic               ramp_finished = 1'b0;

    ramp_result_t pending_ramp[$];
    int           mismatch_count = 0;
    int           idle_cycles    = 0;
    int           burst_left     = 0;

    eased_ramp_generator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // apply one command to the shadow ramp state
    function automatic void apply_command(input logic [1:0] kind, input logic [15:0] ticks);
        logic [16:0] sum;
        case (kind)
            KIND_PLAY: begin
                ramp_playing  = 1'b1;
                ramp_finished = 1'b0;
                ramp_elapsed  = '0;
                if (cfg_duration == 0)
                    ramp_finished = !cfg_loop;
            end
            KIND_STOP: begin
                ramp_playing = 1'b0;
            end
            KIND_RESET: begin
                ramp_playing  = 1'b0;
                ramp_finished = 1'b0;
                ramp_elapsed  = '0;
            end
            default: begin
                if (ramp_playing) begin
                    if (cfg_duration == 0) begin
                        ramp_finished = !cfg_loop;
                    end else begin
                        sum = {1'b0, ramp_elapsed} + {1'b0, ticks};
                        if (sum >= {1'b0, cfg_duration}) begin
                            if (cfg_loop) begin
                                ramp_elapsed = 16'(sum % {1'b0, cfg_duration});
                            end else begin
                                ramp_elapsed  = cfg_duration;
                                ramp_playing  = 1'b0;
                                ramp_finished = 1'b1;
                            end
                        end else begin
                            ramp_elapsed = sum[15:0];
                        end
                    end
                end
            end
        endcase
    endfunction

    // eased value and progress for the current shadow state
    function automatic ramp_result_t ramp_outcome();
        longint       p;
        longint       q;
        longint       eased;
        longint       base;
        longint       span;
        longint       total;
        ramp_result_t r;
        if (cfg_duration == 0) begin
            p = ONE_Q;
        end else begin
            p = (longint'(ramp_elapsed) << 16) / longint'(cfg_duration);
            if (p > ONE_Q)
                p = ONE_Q;
        end
        q = ONE_Q - p;
        case (cfg_ease)
            EASE_IN:  eased = (p * p) >> 16;
            EASE_OUT: eased = ONE_Q - ((q * q) >> 16);
            EASE_INOUT: begin
                if (p < ONE_Q / 2)
                    eased = (2 * p * p) >> 16;
                else
                    eased = ONE_Q - ((2 * q * q) >> 16);
            end
            default:  eased = p;
        endcase
        base  = longint'(cfg_from);
        span  = longint'(cfg_to) - base;
        total = (base * ONE_Q + span * eased) / ONE_Q;
        r.pad      = '0;
        r.finished = ramp_finished;
        r.playing  = ramp_playing;
        r.progress = p[16:0];
        r.value    = total[15:0];
        return r;
    endfunction

    // track register writes and accepted items
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_START:    cfg_from     = pwdata[15:0];
                    REG_END:      cfg_to       = pwdata[15:0];
                    REG_DURATION: cfg_duration = pwdata[15:0];
                    REG_EASE:     cfg_ease     = pwdata[1:0];
                    REG_LOOP:     cfg_loop     = pwdata[0];
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                apply_command(s_tuser, s_tdata);
                pending_ramp.push_back(ramp_outcome());
            end
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin : check_results
        ramp_result_t seen;
        ramp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = ramp_result_t'(m_tdata);
            if (pending_ramp.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item %h", m_tdata);
            end else begin
                want = pending_ramp.pop_front();
                if (seen.value !== want.value || seen.progress !== want.progress ||
                    seen.playing !== want.playing || seen.finished !== want.finished ||
                    seen.pad !== want.pad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: expected value %0d progress %0d ",
                                  "playing %0b finished %0b pad %h, got value %0d ",
                                  "progress %0d playing %0b finished %0b pad %h"},
                                 $signed(want.value), want.progress, want.playing,
                                 want.finished, want.pad, $signed(seen.value),
                                 seen.progress, seen.playing, seen.finished, seen.pad);
                end
            end
        end
    end

    // cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // receiver stalls, one pattern per stretch
    initial begin
        stall_mode_t mode;
        int          stretch;
        m_tready = 1'b0;
        forever begin
            mode    = stall_mode_t'($urandom_range(0, 3));
            stretch = $urandom_range(20, 200);
            repeat (stretch) begin
                @(negedge aclk);
                case (mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: m_tready <= ($urandom_range(0, 5) == 0);
                    default:      m_tready <= ~m_tready;
                endcase
            end
        end
    end

    // send one item, in bursts with gaps between them
    task automatic send_item(input logic [1:0] kind, input logic [15:0] ticks);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ticks;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        @(negedge aclk);
    endtask

    // wait until every expected result has arrived and the block has settled
    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_ramp.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // setup and access cycle of one register write
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // write all registers while idle, with junk in the unused upper bits
    task automatic configure(input logic [15:0] from_v, input logic [15:0] to_v,
                             input logic [15:0] dur, input logic [1:0] ease,
                             input logic loop_on);
        logic [31:0] junk;
        drain_results();
        junk = $urandom;
        write_reg(REG_START, {junk[31:16], from_v});
        junk = $urandom;
        write_reg(REG_END, {junk[31:16], to_v});
        junk = $urandom;
        write_reg(REG_DURATION, {junk[31:16], dur});
        junk = $urandom;
        write_reg(REG_EASE, {junk[31:2], ease});
        junk = $urandom;
        write_reg(REG_LOOP, {junk[31:1], loop_on});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // reset values: zero duration, not looping
    task automatic test_idle_defaults();
        send_item(KIND_TICK, 16'hFFFF);
        send_item(KIND_PLAY, 16'($urandom));
        send_item(KIND_TICK, 16'd5);
        send_item(KIND_STOP, 16'($urandom));
        send_item(KIND_RESET, 16'($urandom));
    endtask

    // widest span over the longest duration, running past the end
    task automatic test_linear_extremes();
        configure(16'h8000, 16'h7FFF, 16'hFFFF, EASE_LINEAR, 1'b0);
        send_item(KIND_PLAY, 16'h0000);
        send_item(KIND_TICK, 16'h0000);
        send_item(KIND_TICK, 16'h0001);
        send_item(KIND_TICK, 16'h7FFF);
        send_item(KIND_TICK, 16'hFFFF);
    endtask

    // every curve at half way, which is the in-out turning point
    task automatic test_ease_curves();
        logic [1:0] curves[4];
        curves = '{EASE_LINEAR, EASE_IN, EASE_OUT, EASE_INOUT};
        foreach (curves[i]) begin
            configure(16'h7FFF, 16'h8000, 16'd4, curves[i], 1'b0);
            send_item(KIND_PLAY, 16'($urandom));
            send_item(KIND_TICK, 16'd2);
        end
    endtask

    // wrap in loop mode, then zero duration while looping
    task automatic test_loop_wrap();
        configure(16'd100, -16'sd100, 16'd7, EASE_INOUT, 1'b1);
        send_item(KIND_PLAY, 16'($urandom));
        send_item(KIND_TICK, 16'hFFFF);
        send_item(KIND_TICK, 16'd7);
        configure(16'd100, -16'sd100, 16'd0, EASE_OUT, 1'b1);
        send_item(KIND_PLAY, 16'($urandom));
        send_item(KIND_TICK, 16'd3);
    endtask

    // elapsed left above a shortened duration gives progress one
    task automatic test_shortened_duration();
        configure(16'd0, 16'd1000, 16'd100, EASE_LINEAR, 1'b0);
        send_item(KIND_PLAY, 16'($urandom));
        send_item(KIND_TICK, 16'd80);
        configure(16'd0, 16'd1000, 16'd10, EASE_IN, 1'b0);
        send_item(KIND_STOP, 16'($urandom));
        send_item(KIND_TICK, 16'd1);
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_duration();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            3, 4:    return 16'($urandom_range(2, 20));
            5, 6:    return 16'($urandom_range(21, 1000));
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed play and tick runs, with stops, resets and odd counts mixed in
    task automatic test_random_ramps();
        int          counted;
        int          pick;
        logic [1:0]  kind;
        logic [15:0] ticks;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure(pick_level(), pick_level(), pick_duration(),
                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (!ramp_playing && pick < 60)
                    kind = KIND_PLAY;
                else if (pick < 85 || (!ramp_playing && pick < 88))
                    kind = KIND_TICK;
                else if (pick < 91)
                    kind = KIND_PLAY;
                else if (pick < 96)
                    kind = KIND_STOP;
                else
                    kind = KIND_RESET;
                case ($urandom_range(0, 9))
                    0:       ticks = 16'($urandom);
                    1:       ticks = 16'h0000;
                    2:       ticks = 16'hFFFF;
                    default: ticks = 16'($urandom_range(0, cfg_duration / 6 + 1));
                endcase
                if (kind != KIND_TICK || ramp_playing)
                    counted++;
                send_item(kind, ticks);
            end
        end
    endtask

    // reset, tests in turn, final verdict
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_TICK;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_defaults();
        test_linear_extremes();
        test_ease_curves();
        test_loop_wrap();
        test_shortened_duration();
        test_random_ramps();
        drain_results();
        if (mismatch_count == 0 && pending_ramp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
